// ===== rtl/core/ipv4_header_field_extractor_defines.svh =====
// assertion macros for the ipv4 header field extractor
// clk and rst are taken from the module that uses the macro
`ifndef IPV4_HEADER_FIELD_EXTRACTOR_DEFINES_SVH
`define IPV4_HEADER_FIELD_EXTRACTOR_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds in the same cycle
`define IHFE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ihfe check failed");

// condition holds in the next cycle
`define IHFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ihfe check failed");

`else

`define IHFE_ASSERT_SAME(lbl, ante, cons)
`define IHFE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/ihfe_pkg.sv =====
`default_nettype none

package ihfe_pkg;

  // ethertypes
  localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
  localparam logic [15:0] ETYPE_QTAG  = 16'h8100;
  localparam logic [15:0] ETYPE_ADTAG = 16'h88A8;

  // byte positions in the frame
  localparam logic [4:0] L3_PLAIN   = 5'd14;
  localparam logic [4:0] L3_TAGGED  = 5'd18;
  localparam int unsigned POS_TYPE_HI = 12;
  localparam int unsigned POS_TYPE_LO = 13;
  localparam int unsigned POS_TAG_HI  = 16;
  localparam int unsigned POS_TAG_LO  = 17;

  // offsets inside the ipv4 header
  localparam int unsigned REL_IHL     = 0;
  localparam int unsigned REL_FRAG_HI = 6;
  localparam int unsigned REL_FRAG_LO = 7;
  localparam int unsigned REL_PROTO   = 9;
  localparam int unsigned REL_SRC     = 12;
  localparam int unsigned REL_DST     = 16;
  localparam int unsigned IP_HDR_MIN  = 20;
  localparam logic [3:0]  MIN_IHL     = 4'd5;

  // offsets inside the transport header
  localparam int unsigned T_PORT_HI  = 2;
  localparam int unsigned T_PORT_LO  = 3;
  localparam int unsigned T_FLAGS    = 13;
  localparam int unsigned TCP_HDR    = 20;
  localparam int unsigned UDP_HDR    = 8;

  localparam logic [7:0] PROTO_NONE = 8'd0;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam int unsigned LEN_FIELD_MAX = 16383;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_IP  = 2'd1;
  localparam logic [1:0] ST_NOT_IP  = 2'd2;
  localparam logic [1:0] ST_SHORT   = 2'd3;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } ihfe_byte_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] ether_type;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  ip_proto;
    logic [7:0]  flag_bits;
    logic [15:0] dest_port;
    logic [13:0] frame_length;
  } ihfe_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/ihfe_stream_if.sv =====
`default_nettype none

interface ihfe_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ipv4_header_field_extractor.sv =====
// ipv4 header field extractor
//
// frame_in carries one frame byte per request, in wire order, with last_byte
// set on the final byte. result_out carries one result per frame: status,
// ethertype after an optional 802.1Q/802.1ad tag, ipv4 addresses, protocol,
// tcp flags, tcp/udp destination port and the saturated frame length.
// every byte updates a byte counter and a few capture registers; the result
// is registered on the last byte, into the output register or, while the
// receiver stalls, into the spare one. throughput is one byte per cycle while
// the spare result register is empty: a byte is taken whenever it is.
// when the receiver stalls with a result pending, a second result register
// holds the next one; frame_in.ready drops only while both are full, and
// nothing is lost or reordered.
// synchronous reset clears the byte counter, the capture registers and the
// result valids; frame_in.ready stays low while rst is high.
// bytes past MAX_FRAME_BYTES are still taken but only count toward nothing:
// the counter saturates and no field changes.
`default_nettype none

`include "ipv4_header_field_extractor_defines.svh"

module ipv4_header_field_extractor
  import ihfe_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 16383
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ihfe_stream_if.sink   frame_in,
  ihfe_stream_if.source result_out
);

  localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned LW = (CW > 14) ? CW : 14;

  // per-frame capture registers
  logic [CW-1:0] byte_offset;
  logic [4:0]    l3_start;
  logic [15:0]   saved_type;
  logic [3:0]    header_words;
  logic [7:0]    saved_proto;
  logic          later_fragment;
  logic [31:0]   saved_src;
  logic [31:0]   saved_dst;
  logic [7:0]    saved_flags;
  logic [15:0]   saved_port;

  logic [CW-1:0] byte_offset_next;
  logic [4:0]    l3_start_next;
  logic [15:0]   saved_type_next;
  logic [3:0]    header_words_next;
  logic [7:0]    saved_proto_next;
  logic          later_fragment_next;
  logic [31:0]   saved_src_next;
  logic [31:0]   saved_dst_next;
  logic [7:0]    saved_flags_next;
  logic [15:0]   saved_port_next;

  logic          out_valid;
  ihfe_result_t  out_data;
  logic          skid_valid;
  ihfe_result_t  skid_data;
  ihfe_result_t  result_next;

  logic          accept;
  logic          push;
  logic [7:0]    b;
  logic          capture_en;
  logic          type_hit;
  logic [15:0]   type_shift;
  logic          in_l3;
  logic [CW-1:0] rel;
  logic [5:0]    th;
  logic [CW-1:0] t;
  logic [CW-1:0] len;
  logic [LW-1:0] len_ext;
  logic [CW-1:0] l3_ext;
  logic [CW-1:0] hdr_end;

  // handshake: take a byte unless both result registers are full
  assign frame_in.ready   = !rst && !skid_valid;
  assign accept           = frame_in.valid && frame_in.ready;
  assign push             = accept && frame_in.data.last_byte;
  assign result_out.valid = out_valid;
  assign result_out.data  = out_data;

  assign b          = frame_in.data.frame_byte;
  assign capture_en = byte_offset < CW'(MAX_FRAME_BYTES);

  // ethertype shift and tag detection
  assign type_hit = (byte_offset == CW'(POS_TYPE_HI)) || (byte_offset == CW'(POS_TYPE_LO)) ||
                    ((l3_start == L3_TAGGED) &&
                     ((byte_offset == CW'(POS_TAG_HI)) || (byte_offset == CW'(POS_TAG_LO))));
  assign type_shift      = {saved_type[7:0], b};
  assign saved_type_next = (capture_en && type_hit) ? type_shift : saved_type;
  assign l3_start_next   = (capture_en && byte_offset == CW'(POS_TYPE_LO)) ?
                           (((type_shift == ETYPE_QTAG) || (type_shift == ETYPE_ADTAG)) ?
                            L3_TAGGED : L3_PLAIN) : l3_start;

  // offsets relative to the ip and transport headers
  assign in_l3 = (byte_offset >= CW'(L3_PLAIN)) && (byte_offset >= CW'(l3_start_next));
  assign rel   = byte_offset - CW'(l3_start_next);
  assign th    = {header_words, 2'b00};
  assign t     = rel - CW'(th);

  assign byte_offset_next = capture_en ? (byte_offset + CW'(1)) : byte_offset;

  // field capture
  always_comb begin
    header_words_next   = header_words;
    saved_proto_next    = saved_proto;
    later_fragment_next = later_fragment;
    saved_src_next      = saved_src;
    saved_dst_next      = saved_dst;
    saved_flags_next    = saved_flags;
    saved_port_next     = saved_port;
    if (capture_en && in_l3) begin
      if (rel == CW'(REL_IHL)) begin
        header_words_next = b[3:0];
      end else if (rel == CW'(REL_FRAG_HI)) begin
        later_fragment_next = later_fragment | (b[4:0] != 5'd0);
      end else if (rel == CW'(REL_FRAG_LO)) begin
        later_fragment_next = later_fragment | (b != 8'd0);
      end else if (rel == CW'(REL_PROTO)) begin
        saved_proto_next = b;
      end else if (rel >= CW'(REL_SRC) && rel < CW'(REL_DST)) begin
        saved_src_next = {saved_src[23:0], b};
      end else if (rel >= CW'(REL_DST) && rel < CW'(IP_HDR_MIN)) begin
        saved_dst_next = {saved_dst[23:0], b};
      end
      if (rel >= CW'(IP_HDR_MIN) && rel >= CW'(th)) begin
        if (t == CW'(T_PORT_HI) || t == CW'(T_PORT_LO)) begin
          saved_port_next = {saved_port[7:0], b};
        end else if (t == CW'(T_FLAGS)) begin
          saved_flags_next = b;
        end
      end
    end
  end

  // classification on the last byte
  assign len     = byte_offset_next;
  assign len_ext = LW'(len);
  assign l3_ext  = CW'(l3_start_next);
  assign hdr_end = l3_ext + CW'({header_words_next, 2'b00});

  always_comb begin
    result_next              = '0;
    result_next.frame_length = (len_ext > LW'(LEN_FIELD_MAX)) ? 14'(LEN_FIELD_MAX) :
                               len_ext[13:0];
    if (len < CW'(L3_PLAIN) || (l3_start_next == L3_TAGGED && len < CW'(L3_TAGGED))) begin
      result_next.status = ST_SHORT;
    end else begin
      result_next.ether_type = saved_type_next;
      if (saved_type_next != ETYPE_IPV4) begin
        result_next.status = ST_NOT_IP;
      end else if (len < l3_ext + CW'(IP_HDR_MIN) || header_words_next < MIN_IHL ||
                   len < hdr_end || saved_proto_next == PROTO_NONE || later_fragment_next) begin
        result_next.status = ST_BAD_IP;
      end else begin
        result_next.status   = ST_OK;
        result_next.src_addr = saved_src_next;
        result_next.dst_addr = saved_dst_next;
        result_next.ip_proto = saved_proto_next;
        if (saved_proto_next == PROTO_TCP && len >= hdr_end + CW'(TCP_HDR)) begin
          result_next.flag_bits = saved_flags_next;
          result_next.dest_port = saved_port_next;
        end else if (saved_proto_next == PROTO_UDP && len >= hdr_end + CW'(UDP_HDR)) begin
          result_next.dest_port = saved_port_next;
        end
      end
    end
  end

  // capture state: load on every byte, clear after the last one
  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_offset    <= '0;
      l3_start       <= L3_PLAIN;
      saved_type     <= '0;
      header_words   <= '0;
      saved_proto    <= '0;
      later_fragment <= 1'b0;
      saved_src      <= '0;
      saved_dst      <= '0;
      saved_flags    <= '0;
      saved_port     <= '0;
    end else if (accept) begin
      byte_offset    <= byte_offset_next;
      l3_start       <= l3_start_next;
      saved_type     <= saved_type_next;
      header_words   <= header_words_next;
      saved_proto    <= saved_proto_next;
      later_fragment <= later_fragment_next;
      saved_src      <= saved_src_next;
      saved_dst      <= saved_dst_next;
      saved_flags    <= saved_flags_next;
      saved_port     <= saved_port_next;
    end
  end

  // result valids: output register plus one spare behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (result_out.ready) begin
        skid_valid <= 1'b0;
      end
    end else if (out_valid && !result_out.ready) begin
      skid_valid <= push;
    end else begin
      out_valid <= push;
    end
  end

  // result data
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (result_out.ready) begin
        out_data <= skid_data;
      end
    end else if (out_valid && !result_out.ready) begin
      if (push) begin
        skid_data <= result_next;
      end
    end else if (push) begin
      out_data <= result_next;
    end
  end

  // checks
  `IHFE_ASSERT_NEXT(a_last_gives_result, push, out_valid)
  `IHFE_ASSERT_NEXT(a_last_clears_count, push, byte_offset == '0)
  `IHFE_ASSERT_SAME(a_count_bounded, 1'b1, byte_offset <= CW'(MAX_FRAME_BYTES))
  `IHFE_ASSERT_SAME(a_spare_behind_out, skid_valid, out_valid)
  `IHFE_ASSERT_SAME(a_short_no_type, out_valid && out_data.status == ST_SHORT,
                    out_data.ether_type == '0 && out_data.dest_port == '0)
  `IHFE_ASSERT_SAME(a_flags_need_tcp, out_valid && out_data.flag_bits != '0,
                    out_data.status == ST_OK && out_data.ip_proto == PROTO_TCP)

endmodule

`default_nettype wire
